@@ hw/rtl/dmhm_pkg.sv @@
// Shared types, constants and tables for the drive mode and heading manager.
package dmhm_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_MODE    = 3'd1,
        OP_COMMAND = 3'd2,
        OP_RESCUE  = 3'd3,
        OP_STATUS  = 3'd4,
        OP_TARGET  = 3'd5,
        OP_YAW     = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    localparam logic [2:0] MODE_STOP     = 3'd0;
    localparam logic [2:0] MODE_RUN      = 3'd1;
    localparam logic [2:0] MODE_ADJUST   = 3'd2;
    localparam logic [2:0] MODE_SAFETY   = 3'd3;
    localparam logic [2:0] MODE_RECOVERY = 3'd4;
    localparam logic [2:0] MODE_OTHER    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_TURN_THR  = 2'd1;
    localparam logic [1:0] REG_ALIGN_THR = 2'd2;

    localparam logic signed [19:0] PI_Q13      = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
    localparam logic signed [19:0] HALF_PI_Q13 = 20'sd12868;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_ERR,
        ST_RULES,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic step;
        logic use_goal_yaw;
        logic err_latch;
        logic apply;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;
        logic need_atan;
    } t_stat;

    // CORDIC arctangent table, Q7.13 radians.
    function automatic logic signed [19:0] atan_entry(input logic [4:0] i);
        logic signed [19:0] r;
        begin
            unique case (i)
                5'd0:  r = 20'sd6434;
                5'd1:  r = 20'sd3798;
                5'd2:  r = 20'sd2007;
                5'd3:  r = 20'sd1019;
                5'd4:  r = 20'sd511;
                5'd5:  r = 20'sd256;
                5'd6:  r = 20'sd128;
                5'd7:  r = 20'sd64;
                5'd8:  r = 20'sd32;
                5'd9:  r = 20'sd16;
                5'd10: r = 20'sd8;
                5'd11: r = 20'sd4;
                5'd12: r = 20'sd2;
                5'd13: r = 20'sd1;
                default: r = 20'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] mode_code(input logic signed [31:0] v);
        return (v >= 0 && v <= 4) ? v[2:0] : MODE_OTHER;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        begin
            if (v > 32'sd32767) r = 16'sh7fff;
            else if (v < -32'sd32768) r = 16'sh8000;
            else r = v[15:0];
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/dmhm_if.sv @@
// Valid/ready channel interfaces for input and result items.
interface dmhm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_yaw;
    modport source (output valid, operation, value_a, value_b, robot_x, robot_y,
                    robot_yaw, input ready);
    modport sink (input valid, operation, value_a, value_b, robot_x, robot_y,
                  robot_yaw, output ready);
endinterface

interface dmhm_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] out_linear;
    logic signed [15:0] out_angular;
    logic [2:0]  out_mode;
    modport source (output valid, out_linear, out_angular, out_mode, input ready);
    modport sink (input valid, out_linear, out_angular, out_mode, output ready);
endinterface

@@ hw/rtl/drive_mode_heading_manager_top.sv @@
// Top level of the drive mode and heading manager.
//  channel   dir   handshake      payload
//  in        in    valid/ready    operation, value_a, value_b, robot_x/y/yaw
//  out       out   valid/ready    out_linear, out_angular, out_mode
//  cfg       in    write enable   index, 13-bit data
// A store item returns to idle from the iteration state; in run with a turn
// pending a tick takes ATAN_ITERATIONS CORDIC steps, one step a cycle.
// One item at a time; the result holds in the output stage until taken.
// Reset is synchronous and active low; it restores all stored messages.
module drive_mode_heading_manager_top #(
    parameter int unsigned ATAN_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmhm_in_if.sink     in_ch,
    dmhm_out_if.source  out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    dmhm_pkg::t_cmd  cmd;
    dmhm_pkg::t_stat stat;
    logic [4:0] iter;

    dmhm_ctrl #(.ATAN_ITERATIONS(ATAN_ITERATIONS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd), .o_iter(iter)
    );

    dmhm_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_iter(iter), .o_stat(stat),
        .i_operation(in_ch.operation), .i_value_a(in_ch.value_a),
        .i_value_b(in_ch.value_b), .i_robot_x(in_ch.robot_x),
        .i_robot_y(in_ch.robot_y), .i_robot_yaw(in_ch.robot_yaw),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_out_linear(out_ch.out_linear), .o_out_angular(out_ch.out_angular),
        .o_out_mode(out_ch.out_mode)
    );
endmodule

@@ hw/rtl/dmhm_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
module dmhm_ctrl #(
    parameter int unsigned ATAN_ITERATIONS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dmhm_pkg::t_stat   i_stat,
    output dmhm_pkg::t_cmd    o_cmd,
    output logic [4:0]        o_iter
);
    dmhm_pkg::t_state r_state, n_state;
    logic [4:0] r_iter, n_iter;

    // Hold state and iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmhm_pkg::ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_iter = r_iter;

    // Sequence load, CORDIC steps, error, rules and the result handoff.
    always_comb begin
        n_state = r_state;
        n_iter = r_iter;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            dmhm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_iter = '0;
                    n_state = dmhm_pkg::ST_ITER;
                end
            end
            dmhm_pkg::ST_ITER: begin
                if (!i_stat.is_tick) begin
                    n_state = dmhm_pkg::ST_IDLE;
                end else if (!i_stat.need_atan) begin
                    n_state = dmhm_pkg::ST_ERR;
                end else begin
                    o_cmd.step = 1'b1;
                    n_iter = r_iter + 5'd1;
                    if (r_iter == 5'(ATAN_ITERATIONS - 1)) n_state = dmhm_pkg::ST_ERR;
                end
            end
            dmhm_pkg::ST_ERR: begin
                o_cmd.err_latch = 1'b1;
                o_cmd.use_goal_yaw = !i_stat.need_atan;
                n_state = dmhm_pkg::ST_RULES;
            end
            dmhm_pkg::ST_RULES: begin
                o_cmd.apply = 1'b1;
                n_state = dmhm_pkg::ST_OUT;
            end
            dmhm_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = dmhm_pkg::ST_IDLE;
            end
            default: n_state = dmhm_pkg::ST_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/dmhm_dp.sv @@
// Datapath: stored messages, CORDIC bearing, heading error and mode rules.
module dmhm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmhm_pkg::t_cmd      i_cmd,
    input  logic [4:0]          i_iter,
    output dmhm_pkg::t_stat     o_stat,
    input  logic [2:0]          i_operation,
    input  logic signed [31:0]  i_value_a,
    input  logic signed [31:0]  i_value_b,
    input  logic signed [31:0]  i_robot_x,
    input  logic signed [31:0]  i_robot_y,
    input  logic signed [15:0]  i_robot_yaw,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    output logic signed [15:0]  o_out_linear,
    output logic signed [15:0]  o_out_angular,
    output logic [2:0]          o_out_mode
);
    logic [9:0]  r_gain;
    logic [12:0] r_turn_thr, r_align_thr;
    logic [2:0]  r_mode, r_rstat;
    logic        r_pending, r_recov, r_tick;
    logic signed [15:0] r_lin, r_ang, r_rlin, r_rang, r_gyaw, r_yaw;
    logic signed [31:0] r_gx, r_gy;
    logic signed [34:0] r_x, r_y, n_x, n_y;
    logic signed [19:0] r_z, n_z, r_err;
    logic r_zero;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 10'd384;
            r_turn_thr <= 13'd1430;
            r_align_thr <= 13'd143;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dmhm_pkg::REG_GAIN) r_gain <= i_cfg_data[9:0];
            if (i_cfg_index == dmhm_pkg::REG_TURN_THR) r_turn_thr <= i_cfg_data;
            if (i_cfg_index == dmhm_pkg::REG_ALIGN_THR) r_align_thr <= i_cfg_data;
        end
    end

    assign o_stat.is_tick = r_tick;
    assign o_stat.need_atan = r_pending && (r_mode == dmhm_pkg::MODE_RUN);

    // Pre-rotation of the target offset.
    logic signed [34:0] dx, dy;
    assign dx = 35'(r_gx) - 35'(i_robot_x);
    assign dy = 35'(r_gy) - 35'(i_robot_y);

    // One CORDIC step.
    logic signed [34:0] xs, ys;
    assign xs = r_x >>> i_iter;
    assign ys = r_y >>> i_iter;
    always_comb begin
        if (r_y > 0) begin
            n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + dmhm_pkg::atan_entry(i_iter);
        end else begin
            n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - dmhm_pkg::atan_entry(i_iter);
        end
    end

    // Heading error, wrapped once (inputs keep it within two turns).
    logic signed [19:0] raw, wr;
    assign raw = (i_cmd.use_goal_yaw ? 20'(r_gyaw) : (r_zero ? 20'sd0 : r_z)) - 20'(r_yaw);
    always_comb begin
        if (raw > dmhm_pkg::PI_Q13) wr = raw - dmhm_pkg::TWO_PI_Q13;
        else if (raw < -dmhm_pkg::PI_Q13) wr = raw + dmhm_pkg::TWO_PI_Q13;
        else wr = raw;
    end

    // Turn rate and magnitude from the latched error.
    logic signed [31:0] prod;
    logic signed [22:0] rate;
    logic [19:0] mag;
    assign prod = 32'(r_err) * $signed({22'd0, r_gain}) + 32'sd256;
    assign rate = 23'(prod >>> 9);
    assign mag = r_err[19] ? 20'(-r_err) : 20'(r_err);
    logic signed [15:0] rate16;
    assign rate16 = dmhm_pkg::sat16(32'(rate));

    // Store messages, run CORDIC, apply rules in order.
    always_ff @(posedge i_clk) begin
        logic [2:0] m;
        logic p, rc;
        logic signed [15:0] l, a;
        if (!i_rst_n) begin
            r_mode <= dmhm_pkg::MODE_STOP; r_pending <= 1'b1; r_recov <= 1'b0;
            r_lin <= '0; r_ang <= '0; r_rlin <= '0; r_rang <= '0;
            r_rstat <= dmhm_pkg::MODE_OTHER; r_gx <= '0; r_gy <= '0; r_gyaw <= '0;
            r_tick <= 1'b0;
        end else begin
            m = r_mode; p = r_pending; rc = r_recov; l = r_lin; a = r_ang;
            if (i_cmd.load) begin
                r_tick <= (dmhm_pkg::t_op'(i_operation) == dmhm_pkg::OP_TICK);
                unique case (dmhm_pkg::t_op'(i_operation))
                    dmhm_pkg::OP_TICK: begin
                        r_yaw <= i_robot_yaw;
                        r_zero <= (dx == 0) && (dy == 0);
                        if (dx < 0) begin
                            if (dy >= 0) begin
                                r_x <= dy; r_y <= -dx; r_z <= dmhm_pkg::HALF_PI_Q13;
                            end else begin
                                r_x <= -dy; r_y <= dx; r_z <= -dmhm_pkg::HALF_PI_Q13;
                            end
                        end else begin
                            r_x <= dx; r_y <= dy; r_z <= '0;
                        end
                    end
                    dmhm_pkg::OP_MODE: r_mode <= dmhm_pkg::mode_code(i_value_a);
                    dmhm_pkg::OP_COMMAND: begin
                        r_lin <= dmhm_pkg::sat16(i_value_a);
                        r_ang <= dmhm_pkg::sat16(i_value_b);
                    end
                    dmhm_pkg::OP_RESCUE: begin
                        r_rlin <= dmhm_pkg::sat16(i_value_a);
                        r_rang <= dmhm_pkg::sat16(i_value_b);
                    end
                    dmhm_pkg::OP_STATUS: r_rstat <= dmhm_pkg::mode_code(i_value_a);
                    dmhm_pkg::OP_TARGET: begin r_gx <= i_value_a; r_gy <= i_value_b; end
                    dmhm_pkg::OP_YAW: r_gyaw <= dmhm_pkg::sat16(i_value_a);
                    default: ;
                endcase
            end
            if (i_cmd.step) begin
                r_x <= n_x; r_y <= n_y; r_z <= n_z;
            end
            if (i_cmd.err_latch) r_err <= wr;
            if (i_cmd.apply) begin
                if (p && m == dmhm_pkg::MODE_RUN) begin
                    l = '0; a = rate16;
                    if (mag < 20'(r_turn_thr)) p = 1'b0;
                end
                if (m == dmhm_pkg::MODE_STOP) begin
                    l = '0; a = '0; p = 1'b1;
                end
                if (m == dmhm_pkg::MODE_ADJUST) begin
                    l = '0; a = rate16;
                    if (mag < 20'(r_align_thr)) m = dmhm_pkg::MODE_STOP;
                end
                if (r_rstat == dmhm_pkg::MODE_SAFETY) m = dmhm_pkg::MODE_SAFETY;
                if (r_rstat == dmhm_pkg::MODE_RUN && m == dmhm_pkg::MODE_SAFETY)
                    m = dmhm_pkg::MODE_RUN;
                if (r_rstat == dmhm_pkg::MODE_RECOVERY) begin
                    rc = 1'b1; m = dmhm_pkg::MODE_RECOVERY; l = r_rlin; a = r_rang;
                end
                if (rc && r_rstat != dmhm_pkg::MODE_RECOVERY) begin
                    rc = 1'b0; p = 1'b1; m = dmhm_pkg::MODE_RUN;
                end
                r_mode <= m; r_pending <= p; r_recov <= rc; r_lin <= l; r_ang <= a;
            end
        end
    end

    assign o_out_linear = r_lin;
    assign o_out_angular = r_ang;
    assign o_out_mode = r_mode;
endmodule
